// File: rtl/assert_macros.svh
// Assertion macros used by the allocator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on i_clk, off while reset is asserted.
`define AST_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk, off while reset is asserted.
`define AST_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/nfsa_pkg.sv
// Package of types and constants for the next-fit slot allocator.
`default_nettype none

package nfsa_pkg;

    // Pool geometry: the used map is stored as ROWS words of WORD_W bits.
    localparam int SLOT_COUNT = 128;
    localparam int WORD_W     = 32;
    localparam int ROWS       = SLOT_COUNT / WORD_W;
    localparam int SLOT_W     = $clog2(SLOT_COUNT);
    localparam int OFF_W      = $clog2(WORD_W);
    localparam int ROW_W      = $clog2(ROWS);
    localparam int PASS_W     = $clog2(ROWS + 1);

    // Field widths of the beats.
    localparam int ID_W     = 7;
    localparam int STATUS_W = 2;

    typedef enum logic {
        MODE_ALLOC = 1'b0,
        MODE_FREE  = 1'b1
    } t_mode;

    typedef enum logic [STATUS_W-1:0] {
        ST_GRANTED  = 2'd0,
        ST_FULL     = 2'd1,
        ST_FREED    = 2'd2,
        ST_BAD_FREE = 2'd3
    } t_status;

    typedef enum logic {
        S_IDLE  = 1'b0,
        S_CHECK = 1'b1
    } t_state;

    typedef struct packed {
        t_mode           mode;
        logic [ID_W-1:0] slot_id;
    } t_request;

    typedef struct packed {
        logic [ID_W-1:0] granted_slot;
        t_status         status;
    } t_result;

endpackage

`default_nettype wire

// File: rtl/next_fit_slot_allocator.sv
// Next-fit slot allocator: used map in a word-wide RAM with a rotating search pointer.
`default_nettype none

// A request beat is taken when start is high and busy is low; exactly one result
// beat follows, shown on o_result for a single cycle with o_strobe high. The
// receiver cannot hold results off, so it must take o_result whenever o_strobe
// is set. A free reads the addressed used-map word once and then returns to idle.
// An allocate reads the used-map words in turn, starting at the pointer word and
// stepping on until a free slot turns up; with 128 slots in four 32-bit words the
// longest search is a full pool, which wraps back to the start word. The search
// pace is set by the used-map RAM, which yields one word per cycle to the search. The result strobe
// comes in the cycle after the last search cycle, and busy is already low then.
// The used map needs no clearing pass after reset: a valid bit per word makes
// unwritten words read as all free, so the block is ready in the first cycle
// after reset.

module next_fit_slot_allocator
    import nfsa_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     start,
    input  wire t_request i_req,
    output logic          busy,
    output logic          o_strobe,
    output t_result       o_result
);

    `include "assert_macros.svh"

    // Used-map storage and its per-word valid bits
    logic [WORD_W-1:0] mem [ROWS];
    logic [ROWS-1:0]   r_valid;

    // Control and datapath registers
    t_state            r_state, n_state;
    logic [SLOT_W-1:0] r_ptr, n_ptr;
    logic [ROW_W-1:0]  r_row, n_row;
    logic [OFF_W-1:0]  r_off, n_off;
    logic [PASS_W-1:0] r_pass, n_pass;
    t_mode             r_mode, n_mode;
    logic              r_inrange, n_inrange;
    logic [WORD_W-1:0] r_rdata;
    logic              r_rvalid;
    logic              r_strobe, n_strobe;
    t_result           r_result, n_result;

    // Write port controls
    logic              wr_en;
    logic [WORD_W-1:0] wr_data;

    // Search helpers
    logic [WORD_W-1:0] word;
    logic [WORD_W-1:0] mask_hi;
    logic [WORD_W-1:0] mask;
    logic [WORD_W-1:0] free_vec;
    logic [OFF_W-1:0]  hit_off;
    logic              hit;
    logic [SLOT_W-1:0] hit_slot;
    logic [ROW_W-1:0]  row_next;

    // Word as seen by the search: unwritten words are all free
    assign word    = r_rvalid ? r_rdata : '0;
    assign mask_hi = {WORD_W{1'b1}} << r_off;

    always_comb begin
        priority if (r_pass == PASS_W'(0)) begin
            mask = mask_hi;
        end else if (r_pass == PASS_W'(ROWS)) begin
            mask = ~mask_hi;
        end else begin
            mask = '1;
        end
    end

    assign free_vec = ~word & mask;
    assign hit      = |free_vec;
    assign hit_slot = {r_row, hit_off};
    assign row_next = (r_row == ROW_W'(ROWS - 1)) ? '0 : r_row + ROW_W'(1);

    // Lowest free bit of the masked word
    always_comb begin
        hit_off = '0;
        for (int i = WORD_W - 1; i >= 0; i--) begin
            if (free_vec[i]) begin
                hit_off = OFF_W'(i);
            end
        end
    end

    // Next state, read address and result
    always_comb begin
        n_state   = r_state;
        n_ptr     = r_ptr;
        n_row     = r_row;
        n_off     = r_off;
        n_pass    = r_pass;
        n_mode    = r_mode;
        n_inrange = r_inrange;
        n_strobe  = 1'b0;
        n_result  = r_result;
        wr_en     = 1'b0;
        wr_data   = word;
        busy      = (r_state != S_IDLE);

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_state   = S_CHECK;
                    n_mode    = i_req.mode;
                    n_pass    = '0;
                    n_inrange = (int'(i_req.slot_id) < SLOT_COUNT);
                    if (i_req.mode == MODE_ALLOC) begin
                        n_row = r_ptr[SLOT_W-1:OFF_W];
                        n_off = r_ptr[OFF_W-1:0];
                    end else begin
                        n_row = i_req.slot_id[SLOT_W-1:OFF_W];
                        n_off = i_req.slot_id[OFF_W-1:0];
                    end
                end
            end
            S_CHECK: begin
                if (r_mode == MODE_FREE) begin
                    // Free: clear the bit if it was in use
                    n_state               = S_IDLE;
                    n_strobe              = 1'b1;
                    n_result.granted_slot = '0;
                    if (r_inrange && word[r_off]) begin
                        wr_en            = 1'b1;
                        wr_data[r_off]   = 1'b0;
                        n_result.status  = ST_FREED;
                    end else begin
                        n_result.status  = ST_BAD_FREE;
                    end
                end else if (hit) begin
                    // Allocate: take the first free slot and move the pointer past it
                    n_state               = S_IDLE;
                    n_strobe              = 1'b1;
                    wr_en                 = 1'b1;
                    wr_data[hit_off]      = 1'b1;
                    n_result.granted_slot = ID_W'(hit_slot);
                    n_result.status       = ST_GRANTED;
                    n_ptr = (hit_slot == SLOT_W'(SLOT_COUNT - 1)) ?
                            '0 : hit_slot + SLOT_W'(1);
                end else if (r_pass == PASS_W'(ROWS)) begin
                    // Wrapped back to the start word: pool full
                    n_state               = S_IDLE;
                    n_strobe              = 1'b1;
                    n_result.granted_slot = '0;
                    n_result.status       = ST_FULL;
                end else begin
                    // Step to the next word
                    n_row  = row_next;
                    n_pass = r_pass + PASS_W'(1);
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr    <= '0;
            r_valid  <= '0;
            r_strobe <= 1'b0;
            r_pass   <= '0;
        end else begin
            r_ptr    <= n_ptr;
            r_strobe <= n_strobe;
            r_pass   <= n_pass;
            if (wr_en) begin
                r_valid[r_row] <= 1'b1;
            end
        end
    end

    // Payload registers and the registered read of the used map
    always_ff @(posedge i_clk) begin
        r_row     <= n_row;
        r_off     <= n_off;
        r_mode    <= n_mode;
        r_inrange <= n_inrange;
        r_result  <= n_result;
        r_rdata   <= mem[n_row];
        r_rvalid  <= r_valid[n_row];
    end

    // Used-map write port
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[r_row] <= wr_data;
        end
    end

    assign o_strobe = r_strobe;
    assign o_result = r_result;

    // Checks
    `AST_IMPLY(a_strobe_idle, o_strobe, !busy, "result beat while busy")
    `AST_NEXT(a_accept_busy, start && !busy, busy, "accepted beat did not start work")
    `AST_IMPLY(a_zero_slot, o_strobe && (o_result.status != ST_GRANTED),
               o_result.granted_slot == '0, "nonzero slot on a result without grant")
    `AST_IMPLY(a_pass_bound, busy, r_pass <= PASS_W'(ROWS), "search ran past the pool")

endmodule

`default_nettype wire

// File: test/testbench.sv
// Self-checking testbench for the next-fit slot allocator.
module testbench
    import nfsa_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT   = 1000;
    localparam int RANDOM_ITEMS = 500;

    // One row of the directed script; known rows carry a hand-typed result.
    typedef struct {
        t_request req;
        bit       known;
        t_result  want;
    } t_script_row;

    logic     i_clk    = 1'b0;
    logic     i_rst_n  = 1'b0;
    logic     start    = 1'b0;
    t_request req_beat = '0;
    logic     busy;
    logic     o_strobe;
    t_result  o_result;

    // Predicted state of the pool
    logic [SLOT_COUNT-1:0] slot_used = '0;
    int unsigned           scan_ptr  = 0;

    t_result     pending_grants[$];
    t_script_row script[$];
    t_result     grant_want;
    int          error_count = 0;
    int          idle_cycles = 0;
    int          items_sent  = 0;
    int          burst_left  = 0;

    next_fit_slot_allocator DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_req    (req_beat),
        .busy     (busy),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Next-fit allocate or free against the predicted pool
    function automatic t_result apply_request(t_request r);
        t_result     res;
        int unsigned pos;
        bit          hit;
        res.granted_slot = '0;
        res.status       = ST_FULL;
        hit              = 1'b0;
        if (scan_ptr >= SLOT_COUNT) scan_ptr = 0;
        if (r.mode == MODE_ALLOC) begin
            pos = scan_ptr;
            for (int n = 0; n < SLOT_COUNT && !hit; n++) begin
                if (!slot_used[pos]) hit = 1'b1;
                else pos = (pos + 1) % SLOT_COUNT;
            end
            if (hit) begin
                slot_used[pos]   = 1'b1;
                res.granted_slot = pos[ID_W-1:0];
                res.status       = ST_GRANTED;
                scan_ptr         = (pos + 1) % SLOT_COUNT;
            end
        end else if (r.slot_id < SLOT_COUNT && slot_used[r.slot_id]) begin
            slot_used[r.slot_id] = 1'b0;
            res.status           = ST_FREED;
        end else begin
            res.status = ST_BAD_FREE;
        end
        return res;
    endfunction

    // A slot currently in use, found from a random offset; random if none
    function automatic logic [ID_W-1:0] pick_used_slot();
        int unsigned base;
        int unsigned pos;
        base = $urandom_range(0, SLOT_COUNT - 1);
        for (int n = 0; n < SLOT_COUNT; n++) begin
            pos = (base + n) % SLOT_COUNT;
            if (slot_used[pos]) return pos[ID_W-1:0];
        end
        return ID_W'($urandom_range(0, SLOT_COUNT - 1));
    endfunction

    function automatic t_request make_req(t_mode m, logic [ID_W-1:0] id);
        t_request r;
        r.mode    = m;
        r.slot_id = id;
        return r;
    endfunction

    task automatic add_row(t_mode m, logic [ID_W-1:0] id, bit known,
                           logic [ID_W-1:0] slot, t_status st);
        t_script_row row;
        row.req               = make_req(m, id);
        row.known             = known;
        row.want.granted_slot = slot;
        row.want.status       = st;
        script.push_back(row);
    endtask

    // Stop sending until every outstanding result has come back
    task automatic hold_until_drained();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending_grants.size() != 0) @(posedge i_clk);
        burst_left = 0;
    endtask

    // Drive one request beat, pacing in bursts, and log its expected result
    task automatic send_request(t_request r, bit known, t_result typed);
        int      gap;
        t_result predicted;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                start <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        start    <= 1'b1;
        req_beat <= r;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        predicted = apply_request(r);
        pending_grants.push_back(known ? typed : predicted);
        items_sent++;
    endtask

    task automatic send_random(t_mode m, bit from_used);
        t_result none;
        none = '0;
        send_request(make_req(m, from_used ? pick_used_slot()
                                           : ID_W'($urandom_range(0, 127))), 1'b0, none);
    endtask

    // Result check: one beat per strobe against the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) begin
            if (pending_grants.size() == 0) begin
                error_count++;
                $display("%0t: unexpected result beat slot=%0d status=%0d",
                         $time, o_result.granted_slot, o_result.status);
            end else begin
                grant_want = pending_grants.pop_front();
                if (o_result.granted_slot !== grant_want.granted_slot) begin
                    error_count++;
                    $display("%0t: granted_slot expected %0d actual %0d",
                             $time, grant_want.granted_slot, o_result.granted_slot);
                end
                if (o_result.status !== grant_want.status) begin
                    error_count++;
                    $display("%0t: status expected %0d actual %0d",
                             $time, grant_want.status, o_result.status);
                end
            end
        end
    end

    // Watchdog on cycles with no beat moving in either direction
    always @(posedge i_clk) begin
        if ((start && !busy) || o_strobe) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        int        kind;
        int        seg_len;
        t_mode     m;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed script: next-fit order past freed slots, frees of free slots
        add_row(MODE_ALLOC, 7'h7F, 1, 7'd0, ST_GRANTED);
        add_row(MODE_ALLOC, 7'h00, 1, 7'd1, ST_GRANTED);
        add_row(MODE_FREE,  7'h00, 1, 7'd0, ST_FREED);
        add_row(MODE_FREE,  7'h00, 1, 7'd0, ST_BAD_FREE);
        add_row(MODE_FREE,  7'h7F, 1, 7'd0, ST_BAD_FREE);
        add_row(MODE_ALLOC, 7'h55, 1, 7'd2, ST_GRANTED);
        add_row(MODE_ALLOC, 7'h2A, 1, 7'd3, ST_GRANTED);
        add_row(MODE_FREE,  7'h02, 1, 7'd0, ST_FREED);
        add_row(MODE_FREE,  7'h01, 1, 7'd0, ST_FREED);
        add_row(MODE_ALLOC, 7'h7F, 1, 7'd4, ST_GRANTED);
        add_row(MODE_FREE,  7'h03, 1, 7'd0, ST_FREED);
        add_row(MODE_FREE,  7'h04, 1, 7'd0, ST_FREED);
        add_row(MODE_FREE,  7'h7F, 1, 7'd0, ST_BAD_FREE);
        add_row(MODE_ALLOC, 7'h00, 1, 7'd5, ST_GRANTED);
        add_row(MODE_ALLOC, 7'h40, 0, 7'd0, ST_GRANTED);
        add_row(MODE_ALLOC, 7'h01, 0, 7'd0, ST_GRANTED);
        add_row(MODE_FREE,  7'h06, 0, 7'd0, ST_GRANTED);
        add_row(MODE_FREE,  7'h05, 0, 7'd0, ST_GRANTED);
        add_row(MODE_FREE,  7'h07, 0, 7'd0, ST_GRANTED);
        foreach (script[i]) send_request(script[i].req, script[i].known, script[i].want);

        // Random part: first fill the pool past full, then mixed segments
        kind = 0;
        while (items_sent < script.size() + RANDOM_ITEMS) begin
            unique case (kind)
                0: begin
                    // fill until full, then a few allocates against a full pool
                    while (!(&slot_used)) send_random(MODE_ALLOC, 1'b0);
                    repeat ($urandom_range(1, 4)) send_random(MODE_ALLOC, 1'b0);
                end
                1: begin
                    // drain: mostly frees of slots in use, some stray frees
                    seg_len = $urandom_range(10, 60);
                    repeat (seg_len) send_random(MODE_FREE, $urandom_range(0, 4) != 0);
                end
                default: begin
                    seg_len = $urandom_range(20, 80);
                    repeat (seg_len) begin
                        m = t_mode'($urandom_range(0, 1));
                        send_random(m, $urandom_range(0, 1) != 0);
                    end
                end
            endcase
            if (items_sent < script.size() + 200 || $urandom_range(0, 2) == 0)
                hold_until_drained();
            kind = $urandom_range(0, 2);
        end

        // Wait for the tail of results, then a few more cycles for strays
        start <= 1'b0;
        @(posedge i_clk);
        while (pending_grants.size() != 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);
        if (error_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// File: next_fit_slot_allocator.f
+incdir+rtl
rtl/nfsa_pkg.sv
rtl/next_fit_slot_allocator.sv
test/testbench.sv
